// ===== sv/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// tgarle_pkg
// shared constants and types for the tga run-length pixel decoder
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam int unsigned ADDR_W   = 3;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned COUNT_W  = 25;
   localparam int unsigned FORMAT_W = 2;

   localparam int unsigned MAX_PIXELS_DEFAULT = 16777216;

   // pixel format codes
   localparam logic [FORMAT_W-1:0] FMT_GREY = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_RGB  = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_RGBA = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_COUNT  = 1'b1;

   localparam logic [FORMAT_W-1:0] FORMAT_RESET = FMT_RGB;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 25'd1;

   typedef struct packed {
      logic [FORMAT_W-1:0] pixel_format;
      logic [COUNT_W-1:0]  image_size;
   } cfg_type;

endpackage

// ===== sv/tgarle_regs.sv =====
// ----------------------------------------------------------------------------
// tgarle_regs
// apb register file: pixel format and pixel count, with the clamped image size
// ----------------------------------------------------------------------------
module tgarle_regs #(
   parameter int unsigned MAX_PIXELS = tgarle_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tgarle_pkg::ADDR_W-1:0]   paddr,
   input  logic [tgarle_pkg::DATA_W-1:0]   pwdata,
   output logic [tgarle_pkg::DATA_W-1:0]   prdata,
   output logic                            pready,
   output tgarle_pkg::cfg_type             cfg
);

   localparam logic [tgarle_pkg::COUNT_W-1:0] MaxCount = tgarle_pkg::COUNT_W'(MAX_PIXELS);

   logic [tgarle_pkg::FORMAT_W-1:0] pixel_format_ff, pixel_format_in;
   logic [tgarle_pkg::COUNT_W-1:0]  pixel_count_ff, pixel_count_in;
   logic                            wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      pixel_format_in = pixel_format_ff;
      pixel_count_in  = pixel_count_ff;
      if (wr_en) begin
         unique case (paddr[2])
            tgarle_pkg::REG_FORMAT: pixel_format_in = pwdata[tgarle_pkg::FORMAT_W-1:0];
            tgarle_pkg::REG_COUNT:  pixel_count_in  = pwdata[tgarle_pkg::COUNT_W-1:0];
            default:                pixel_count_in  = pixel_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= tgarle_pkg::FORMAT_RESET;
         pixel_count_ff  <= tgarle_pkg::COUNT_RESET;
      end else begin
         pixel_format_ff <= pixel_format_in;
         pixel_count_ff  <= pixel_count_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         tgarle_pkg::REG_FORMAT:
            prdata = tgarle_pkg::DATA_W'(pixel_format_ff);
         tgarle_pkg::REG_COUNT:
            prdata = tgarle_pkg::DATA_W'(pixel_count_ff);
         default:
            prdata = '0;
      endcase
   end

   // zero counts as one pixel, large counts saturate
   always_comb begin
      cfg.pixel_format = pixel_format_ff;
      if (pixel_count_ff == '0) begin
         cfg.image_size = tgarle_pkg::COUNT_W'(1);
      end else if (pixel_count_ff > MaxCount) begin
         cfg.image_size = MaxCount;
      end else begin
         cfg.image_size = pixel_count_ff;
      end
   end

endmodule

// ===== sv/tga_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length coded tga image data decoder, one byte per beat, one pixel per result
// ----------------------------------------------------------------------------
// path: an accepted byte passes the input register, then the result register
// throughput: 1 byte per cycle unless a pixel result waits on rsp_ready;
//   the packet state updates in one pass per byte
// reset: synchronous, clears the pipeline, the packet state and the registers
//   (pixel_format 1, pixel_count 1)
module tga_rle_pixel_decoder #(
   parameter int unsigned MAX_PIXELS = tgarle_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_blue,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_alpha,
   output logic [7:0]                      rsp_repeat_res,
   output logic                            rsp_last_pixel,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tgarle_pkg::ADDR_W-1:0]   paddr,
   input  logic [tgarle_pkg::DATA_W-1:0]   pwdata,
   output logic [tgarle_pkg::DATA_W-1:0]   prdata,
   output logic                            pready
);

   localparam int unsigned CW = tgarle_pkg::COUNT_W;

   tgarle_pkg::cfg_type cfg;

   tgarle_regs #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;

   // packet state
   logic          expect_header_ff, expect_header_in;
   logic          run_packet_ff, run_packet_in;
   logic [7:0]    left_ff, left_in;
   logic [1:0]    byte_idx_ff, byte_idx_in;
   logic [23:0]   held_ff, held_in;
   logic [CW-1:0] done_ff, done_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    blue_ff, blue_in;
   logic [7:0]    green_ff, green_in;
   logic [7:0]    red_ff, red_in;
   logic [7:0]    alpha_ff, alpha_in;
   logic [7:0]    repeat_ff, repeat_in;
   logic          last_ff, last_in;

   logic          has_colour, alpha_fmt;
   logic [1:0]    last_idx;
   logic          pixel_end, emits, out_free, advance;
   logic [31:0]   word;
   logic [CW-1:0] remain, done_sum;
   logic [7:0]    rep, left_dec;
   logic          image_end;

   assign has_colour = (cfg.pixel_format != tgarle_pkg::FMT_GREY);
   assign alpha_fmt  = (cfg.pixel_format == tgarle_pkg::FMT_RGBA);

   always_comb begin
      unique case (cfg.pixel_format)
         tgarle_pkg::FMT_GREY: last_idx = 2'd0;
         tgarle_pkg::FMT_RGBA: last_idx = 2'd3;
         default:              last_idx = 2'd2;
      endcase
   end

   assign pixel_end = (byte_idx_ff >= last_idx);
   assign emits     = in_valid_ff && !expect_header_ff && pixel_end;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!emits || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign word     = {8'd0, held_ff} | ({24'd0, in_byte_ff} << {byte_idx_ff, 3'b000});
   assign remain   = cfg.image_size - done_ff;
   assign left_dec = left_ff - 8'd1;

   // run length clipped at the image end, one for raw packets
   always_comb begin
      if (!run_packet_ff) begin
         rep = 8'd1;
      end else if (done_ff >= cfg.image_size) begin
         rep = 8'd1;
      end else if (CW'(left_ff) > remain) begin
         rep = remain[7:0];
      end else if (left_ff == 8'd0) begin
         rep = 8'd1;
      end else begin
         rep = left_ff;
      end
   end

   assign done_sum  = done_ff + CW'(rep);
   assign image_end = (done_sum >= cfg.image_size);

   always_comb begin
      in_valid_in      = in_valid_ff;
      in_byte_in       = in_byte_ff;
      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      left_in          = left_ff;
      byte_idx_in      = byte_idx_ff;
      held_in          = held_ff;
      done_in          = done_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      blue_in          = blue_ff;
      green_in         = green_ff;
      red_in           = red_ff;
      alpha_in         = alpha_ff;
      repeat_in        = repeat_ff;
      last_in          = last_ff;

      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
      end

      if (advance) begin
         if (expect_header_ff) begin
            run_packet_in    = in_byte_ff[7];
            left_in          = in_byte_ff[7] ? (in_byte_ff - 8'd127) : (in_byte_ff + 8'd1);
            expect_header_in = 1'b0;
            byte_idx_in      = 2'd0;
            held_in          = '0;
         end else if (!pixel_end) begin
            held_in     = word[23:0];
            byte_idx_in = byte_idx_ff + 2'd1;
         end else begin
            rsp_valid_in = 1'b1;
            blue_in      = word[7:0];
            green_in     = has_colour ? word[15:8] : 8'd0;
            red_in       = has_colour ? word[23:16] : 8'd0;
            alpha_in     = alpha_fmt ? word[31:24] : 8'd0;
            repeat_in    = rep;
            last_in      = image_end;
            byte_idx_in  = 2'd0;
            held_in      = '0;
            if (image_end) begin
               expect_header_in = 1'b1;
               run_packet_in    = 1'b0;
               left_in          = '0;
               done_in          = '0;
            end else begin
               done_in          = done_sum;
               left_in          = run_packet_ff ? 8'd0 : left_dec;
               expect_header_in = run_packet_ff || (left_dec == 8'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         left_ff          <= '0;
         byte_idx_ff      <= '0;
         held_ff          <= '0;
         done_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         left_ff          <= left_in;
         byte_idx_ff      <= byte_idx_in;
         held_ff          <= held_in;
         done_ff          <= done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      blue_ff    <= blue_in;
      green_ff   <= green_in;
      red_ff     <= red_in;
      alpha_ff   <= alpha_in;
      repeat_ff  <= repeat_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_green      = green_ff;
   assign rsp_red        = red_ff;
   assign rsp_alpha      = alpha_ff;
   assign rsp_repeat_res = repeat_ff;
   assign rsp_last_pixel = last_ff;

endmodule

// ===== sv/tgarle_checker.sv =====
// ----------------------------------------------------------------------------
// tgarle_checker
// port-level checks for the tga run-length pixel decoder
// ----------------------------------------------------------------------------
module tgarle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_repeat_res,
   input logic       rsp_last_pixel
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue) && $stable(rsp_green)
         && $stable(rsp_red) && $stable(rsp_alpha) && $stable(rsp_repeat_res)
         && $stable(rsp_last_pixel))
      else $error("result beat changed while stalled");

   // repeat count stays within one packet
   a_repeat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_res != 8'd0 && rsp_repeat_res <= 8'd128)
      else $error("repeat count out of range");

   // reset empties the result register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset empties the input register
   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_blue       (rsp_blue),
   .rsp_green      (rsp_green),
   .rsp_red        (rsp_red),
   .rsp_alpha      (rsp_alpha),
   .rsp_repeat_res (rsp_repeat_res),
   .rsp_last_pixel (rsp_last_pixel)
);
